@@ hdl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the store frame checker
// Header layout constants, status codes, item structs and the bytewise
// CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package sfc_pkg;

	// Header layout and checks
	localparam logic [15:0] SFC_MAGIC        = 16'h5241;
	localparam logic [7:0]  SFC_VERSION      = 8'd1;
	localparam logic [7:0]  SFC_ALGO_ID      = 8'd0;
	localparam logic [31:0] SFC_HEADER_BYTES = 32'd14;

	// CRC-16/CCITT, MSB first, no final xor
	localparam logic [15:0] SFC_CRC_POLY = 16'h1021;
	localparam logic [15:0] SFC_CRC_INIT = 16'hFFFF;

	// Configuration register reset value
	localparam logic [31:0] SFC_CAP_RESET = 32'hFFFF_FFFF;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_FRAME = 3'd1;
	localparam logic [2:0] ST_BAD_ALGO  = 3'd2;
	localparam logic [2:0] ST_NO_SPACE  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC   = 3'd4;

	// Register indexes
	localparam logic REG_DEST_CAPACITY = 1'b0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic [2:0] status;
		logic       last_of_run;
	} out_item_t;

	// Up to two results pushed into the result queue in one cycle
	typedef struct packed {
		logic [1:0] num;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	// One byte of CRC-16/CCITT, bit by bit from the MSB
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ SFC_CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/sfc_if.sv @@
// ----------------------------------------------------------------------------
// sfc_if: valid/ready channels of the store frame checker
// Input channel carries frame bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface sfc_in_if import sfc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfc_out_if import sfc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/store_frame_checker_core.sv @@
// ----------------------------------------------------------------------------
// store_frame_checker_core: streaming check of one stored-archive frame
// Captures the 14-byte header, forwards payload bytes tentatively, runs
// CRC-16/CCITT over the payload and reports one status at the frame end.
//
//   channel   dir   payload                                   transfer
//   in_ch     in    in_byte, frame_end                        valid & ready
//   out_ch    out   out_byte, is_status, status, last_of_run  valid & ready
//   apb       in    dest_capacity at address 0                psel & penable
//
// One byte per cycle sustained while the result queue has room; results pass
// through the input register and the result queue.
// A byte that ends a frame with payload gives two results. Input stalls only
// while the four-entry queue holds more than two results. Reset is
// asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module store_frame_checker_core import sfc_pkg::*; #(
	parameter logic [7:0] STORE_ALGO_ID = SFC_ALGO_ID
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sfc_in_if.sink      in_ch,
	sfc_out_if.source   out_ch
);

	logic [31:0] cap_q;
	logic        cfg_wr;
	logic        space_ok;
	push_t       push;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= SFC_CAP_RESET;
		end else if (cfg_wr && paddr[2] == REG_DEST_CAPACITY) begin
			cap_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_DEST_CAPACITY) ? cap_q : 32'd0;

	sfc_parser #(
		.STORE_ALGO_ID (STORE_ALGO_ID)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_item       (in_ch.data),
		.space_ok      (space_ok),
		.dest_capacity (cap_q),
		.push          (push)
	);

	sfc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.data)
	);

endmodule

@@ hdl/sfc_parser.sv @@
// ----------------------------------------------------------------------------
// sfc_parser: input register, header capture, CRC and status
// Registers one byte, then in a single pass updates the frame state and
// produces the forwarded byte and/or the final status.
// ----------------------------------------------------------------------------
module sfc_parser import sfc_pkg::*; #(
	parameter logic [7:0] STORE_ALGO_ID = SFC_ALGO_ID
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	input  logic        space_ok,
	input  logic [31:0] dest_capacity,
	output push_t       push
);

	// Input register
	logic       valid_s1;
	in_item_t   item_s1;
	logic       advance;

	// Frame state
	logic [31:0] cnt_q, src_q, pay_q;
	logic [15:0] magic_q, exp_crc_q, crc_q;
	logic [7:0]  ver_q, algo_q;

	logic [31:0] cnt_n, src_n, pay_n;
	logic [15:0] magic_n, exp_crc_n, crc_n;
	logic [7:0]  ver_n, algo_n;

	logic        sat;
	logic        fwd;
	logic [31:0] pay_pos;
	logic [32:0] need_total;
	logic [2:0]  st;
	out_item_t   byte_res, stat_res;

	assign advance  = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Header capture and payload CRC
	assign sat     = &cnt_q;
	assign pay_pos = cnt_q - SFC_HEADER_BYTES;

	always_comb begin
		magic_n   = magic_q;
		ver_n     = ver_q;
		algo_n    = algo_q;
		src_n     = src_q;
		pay_n     = pay_q;
		exp_crc_n = exp_crc_q;
		crc_n     = crc_q;
		fwd       = 1'b0;
		if (!sat) begin
			priority if (cnt_q < 32'd2) begin
				if (cnt_q[0]) magic_n[15:8] = item_s1.in_byte;
				else          magic_n[7:0]  = item_s1.in_byte;
			end else if (cnt_q == 32'd2) begin
				ver_n = item_s1.in_byte;
			end else if (cnt_q == 32'd3) begin
				algo_n = item_s1.in_byte;
			end else if (cnt_q < 32'd8) begin
				src_n[8*cnt_q[1:0] +: 8] = item_s1.in_byte;
			end else if (cnt_q < 32'd12) begin
				pay_n[8*cnt_q[1:0] +: 8] = item_s1.in_byte;
			end else if (cnt_q < SFC_HEADER_BYTES) begin
				if (cnt_q[0]) exp_crc_n[15:8] = item_s1.in_byte;
				else          exp_crc_n[7:0]  = item_s1.in_byte;
			end else if (pay_pos < pay_q) begin
				crc_n = crc_byte(crc_q, item_s1.in_byte);
				fwd   = 1'b1;
			end else begin
				fwd = 1'b0;
			end
		end
	end

	// Byte count saturates at all ones
	assign cnt_n = sat ? cnt_q : cnt_q + 32'd1;

	// Status at the final byte, in check order
	assign need_total = {1'b0, pay_n} + {1'b0, SFC_HEADER_BYTES};

	always_comb begin
		priority if (cnt_n < SFC_HEADER_BYTES) begin
			st = ST_BAD_FRAME;
		end else if (magic_n != SFC_MAGIC || ver_n != SFC_VERSION) begin
			st = ST_BAD_FRAME;
		end else if (algo_n != STORE_ALGO_ID) begin
			st = ST_BAD_ALGO;
		end else if (pay_n != src_n) begin
			st = ST_BAD_FRAME;
		end else if (need_total > {1'b0, cnt_n}) begin
			st = ST_BAD_FRAME;
		end else if (dest_capacity < src_n) begin
			st = ST_NO_SPACE;
		end else if (exp_crc_n != crc_n) begin
			st = ST_BAD_CRC;
		end else begin
			st = ST_OK;
		end
	end

	// Result items
	always_comb begin
		byte_res.out_byte    = item_s1.in_byte;
		byte_res.is_status   = 1'b0;
		byte_res.status      = ST_OK;
		byte_res.last_of_run = !item_s1.frame_end;
		stat_res.out_byte    = 8'd0;
		stat_res.is_status   = 1'b1;
		stat_res.status      = st;
		stat_res.last_of_run = 1'b1;
		push.first  = fwd ? byte_res : stat_res;
		push.second = stat_res;
		if (!advance) begin
			push.num = 2'd0;
		end else begin
			push.num = {1'b0, fwd} + {1'b0, item_s1.frame_end};
		end
	end

	// State update; rearm after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			magic_q   <= '0;
			ver_q     <= '0;
			algo_q    <= '0;
			src_q     <= '0;
			pay_q     <= '0;
			exp_crc_q <= '0;
			crc_q     <= SFC_CRC_INIT;
		end else if (advance) begin
			if (item_s1.frame_end) begin
				cnt_q     <= '0;
				magic_q   <= '0;
				ver_q     <= '0;
				algo_q    <= '0;
				src_q     <= '0;
				pay_q     <= '0;
				exp_crc_q <= '0;
				crc_q     <= SFC_CRC_INIT;
			end else begin
				cnt_q     <= cnt_n;
				magic_q   <= magic_n;
				ver_q     <= ver_n;
				algo_q    <= algo_n;
				src_q     <= src_n;
				pay_q     <= pay_n;
				exp_crc_q <= exp_crc_n;
				crc_q     <= crc_n;
			end
		end
	end

endmodule

@@ hdl/sfc_result_fifo.sv @@
// ----------------------------------------------------------------------------
// sfc_result_fifo: four-entry result queue
// Takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module sfc_result_fifo import sfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      space_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	out_item_t  mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	// Room for two results regardless of this cycle's pop
	assign space_ok  = count_q <= 3'd2;
	assign out_valid = count_q != 3'd0;
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.num;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.num} - {2'b00, pop};
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.second;
		end
	end

endmodule

@@ bench/store_frame_checker_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// store_frame_checker_core_test: self-checking bench of the frame checker
// Feeds framed byte streams (directed table first, then random frames that
// are mostly well formed with random corruptions) through the input channel.
// A behavioral model predicts every forwarded byte and the closing status.
// Output results are compared field by field in order. dest_capacity is
// reprogrammed between phases, including its extremes.
// ----------------------------------------------------------------------------
module store_frame_checker_core_test;
	import sfc_pkg::*;

	localparam int          CLK_PERIOD       = 10;
	localparam int          RESET_CYCLES     = 6;
	localparam int          CYCLE_LIMIT      = 200000;
	localparam int          DRAIN_CYCLES     = 8;
	localparam int          RANDOM_PER_PHASE = 340;
	localparam int          SQUEEZE_CYCLES   = 80;
	localparam int          SQUEEZE_STRIDE   = 600;
	localparam logic [2:0]  CAP_ADDR         = 3'(4 * REG_DEST_CAPACITY);
	localparam logic [2:0]  UNUSED_ADDR      = 3'd4;
	localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

	// One row of the directed table; verdict is used only where typed is set
	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t verdict;
	} vec_t;

	localparam out_item_t NO_VERDICT    = '0;
	localparam out_item_t SHORT_VERDICT = '{out_byte: 8'h00, is_status: 1'b1,
		status: ST_BAD_FRAME, last_of_run: 1'b1};
	localparam out_item_t ALGO_VERDICT  = '{out_byte: 8'h00, is_status: 1'b1,
		status: ST_BAD_ALGO, last_of_run: 1'b1};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sfc_in_if  in_ch ();
	sfc_out_if out_ch ();

	store_frame_checker_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Directed frames: a lone byte, a header with an unsupported algorithm
	// whose payload is still forwarded, and a header cut short
	vec_t directed_tab [25] = '{
		'{'{8'hFF, 1'b1}, 1'b1, SHORT_VERDICT},
		'{'{8'h41, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h52, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h01, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'hFF, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h02, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h02, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'hFF, 1'b1}, 1'b1, ALGO_VERDICT},
		'{'{8'h41, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h52, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h01, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h00, 1'b0}, 1'b0, NO_VERDICT},
		'{'{8'h80, 1'b1}, 1'b1, SHORT_VERDICT}
	};

	// Frame tracking state of the model, plus the capacity it checks against
	logic [31:0] cap_shadow;
	logic [31:0] seen_count;
	logic [15:0] magic_acc;
	logic [7:0]  ver_acc;
	logic [7:0]  algo_acc;
	logic [31:0] src_len;
	logic [31:0] pay_len;
	logic [15:0] crc_hdr;
	logic [15:0] crc_run;

	out_item_t frame_results_q [$];
	int        fail_count = 0;
	int        bytes_fed = 0;
	int        cycle_count = 0;
	bit        feed_steady = 1'b0;
	bit        take_steady = 1'b0;

	// CRC-16/CCITT, one input bit at a time against the feedback tap
	function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ SFC_CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void frame_rearm();
		seen_count = '0;
		magic_acc  = '0;
		ver_acc    = '0;
		algo_acc   = '0;
		src_len    = '0;
		pay_len    = '0;
		crc_hdr    = '0;
		crc_run    = SFC_CRC_INIT;
	endfunction

	// Advance the frame model by one accepted byte and queue its results
	function automatic void predict_frame_byte(in_item_t it);
		logic [31:0] pos;
		logic [63:0] total;
		logic [2:0]  verdict;
		out_item_t   res;
		pos = seen_count;
		if (pos != COUNT_MAX) begin
			if (pos < 2) begin
				magic_acc[pos[0]*8 +: 8] = it.in_byte;
			end else if (pos == 2) begin
				ver_acc = it.in_byte;
			end else if (pos == 3) begin
				algo_acc = it.in_byte;
			end else if (pos < 8) begin
				src_len[pos[1:0]*8 +: 8] = it.in_byte;
			end else if (pos < 12) begin
				pay_len[pos[1:0]*8 +: 8] = it.in_byte;
			end else if (pos < SFC_HEADER_BYTES) begin
				crc_hdr[pos[0]*8 +: 8] = it.in_byte;
			end else if (pos - SFC_HEADER_BYTES < pay_len) begin
				crc_run = ccitt_next(crc_run, it.in_byte);
				res = '{out_byte: it.in_byte, is_status: 1'b0, status: ST_OK,
					last_of_run: !it.frame_end};
				frame_results_q.push_back(res);
			end
			seen_count = pos + 1;
		end
		total = 64'(seen_count);

		if (it.frame_end) begin
			if (total < 64'(SFC_HEADER_BYTES)) begin
				verdict = ST_BAD_FRAME;
			end else if (magic_acc != SFC_MAGIC || ver_acc != SFC_VERSION) begin
				verdict = ST_BAD_FRAME;
			end else if (algo_acc != SFC_ALGO_ID) begin
				verdict = ST_BAD_ALGO;
			end else if (pay_len != src_len) begin
				verdict = ST_BAD_FRAME;
			end else if (64'(SFC_HEADER_BYTES) + 64'(pay_len) > total) begin
				verdict = ST_BAD_FRAME;
			end else if (cap_shadow < src_len) begin
				verdict = ST_NO_SPACE;
			end else if (crc_hdr != crc_run) begin
				verdict = ST_BAD_CRC;
			end else begin
				verdict = ST_OK;
			end
			res = '{out_byte: 8'h00, is_status: 1'b1, status: verdict, last_of_run: 1'b1};
			frame_results_q.push_back(res);
			frame_rearm();
		end
	endfunction

	// Offer one byte after a random gap; model it on the transfer
	task automatic send_byte(in_item_t it, logic typed, out_item_t verdict);
		int gap;
		if ($urandom_range(0, 47) == 0) begin
			feed_steady = !feed_steady;
		end
		gap = feed_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_frame_byte(it);
		bytes_fed++;
		// typed status replaces the one just predicted
		if (typed) begin
			frame_results_q[frame_results_q.size() - 1] = verdict;
		end
		@(negedge clk);
	endtask

	// Drop valid and wait until all results are in and the pipe is empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == CAP_ADDR) begin
			cap_shadow = val;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reg_read_check(logic [2:0] addr, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("dest_capacity: expected %08h, actual %08h", want, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Build one frame: mostly proper headers with one random defect or none,
	// some pure noise, some truncated, some with an absurd length
	task automatic send_random_frame();
		logic [7:0]  fb [$];
		logic [7:0]  body [$];
		logic [31:0] src;
		logic [31:0] pay;
		logic [15:0] crc;
		logic [15:0] magic;
		logic [7:0]  ver;
		logic [7:0]  algo;
		logic [7:0]  pb;
		in_item_t    it;
		int          kind;
		int          fill;
		int          n;
		int          cut;
		kind = $urandom_range(0, 13);
		if (kind == 0) begin
			n = $urandom_range(1, 20);
			repeat (n) fb.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (kind == 7) begin
				pay = $urandom();
				n = $urandom_range(0, 10);
			end else begin
				pay = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
					: $urandom_range(0, 16);
				n = int'(pay);
			end
			src  = pay;
			fill = $urandom_range(0, 7);
			crc  = SFC_CRC_INIT;
			for (int i = 0; i < n; i++) begin
				pb = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
				body.push_back(pb);
				crc = ccitt_next(crc, pb);
			end
			magic = SFC_MAGIC;
			ver   = SFC_VERSION;
			algo  = SFC_ALGO_ID;
			case (kind)
				1: magic = magic ^ (16'h1 << $urandom_range(0, 15));
				2: ver   = ver ^ 8'($urandom_range(1, 255));
				3: algo  = algo ^ 8'($urandom_range(1, 255));
				4: src   = src ^ (32'h1 << $urandom_range(0, 31));
				5: crc   = crc ^ 16'($urandom_range(1, 16'hFFFF));
				default: ;
			endcase
			fb.push_back(magic[7:0]);
			fb.push_back(magic[15:8]);
			fb.push_back(ver);
			fb.push_back(algo);
			for (int i = 0; i < 4; i++) fb.push_back(src[i*8 +: 8]);
			for (int i = 0; i < 4; i++) fb.push_back(pay[i*8 +: 8]);
			fb.push_back(crc[7:0]);
			fb.push_back(crc[15:8]);
			for (int i = 0; i < body.size(); i++) fb.push_back(body[i]);
			if (kind == 6) begin
				cut = $urandom_range(1, fb.size() - 1);
				while (fb.size() > cut) void'(fb.pop_back());
			end else begin
				// trailing bytes past the payload are ignored
				repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(0, 255)));
			end
		end
		for (int i = 0; i < fb.size(); i++) begin
			it.in_byte   = fb[i];
			it.frame_end = (i == fb.size() - 1);
			send_byte(it, 1'b0, NO_VERDICT);
		end
	endtask

	// Compare one output transfer against the oldest expectation
	task automatic check_result(out_item_t got);
		out_item_t want;
		if (frame_results_q.size() == 0) begin
			$error("unexpected result: out_byte %02h is_status %0d status %0d last_of_run %0d",
				got.out_byte, got.is_status, got.status, got.last_of_run);
			fail_count++;
		end else begin
			want = frame_results_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				fail_count++;
			end
			if (got.is_status !== want.is_status) begin
				$error("is_status: expected %0d, actual %0d", want.is_status, got.is_status);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				fail_count++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d", want.last_of_run,
					got.last_of_run);
				fail_count++;
			end
		end
	endtask

	// Result side: random ready gaps, with a long hold-off now and then so
	// the result queue fills and the input stalls
	initial begin
		int wait_n;
		int next_squeeze_at;
		out_ch.ready = 1'b0;
		next_squeeze_at = 400;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 47) == 0) begin
				take_steady = !take_steady;
			end
			wait_n = take_steady ? 0 : $urandom_range(0, 6);
			if (bytes_fed >= next_squeeze_at) begin
				wait_n = SQUEEZE_CYCLES;
				next_squeeze_at += SQUEEZE_STRIDE;
			end
			if (wait_n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			check_result(out_ch.data);
			@(negedge clk);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Main sequence
	initial begin
		logic [31:0] cap;
		int          fed_target;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		cap_shadow  = SFC_CAP_RESET;
		frame_rearm();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		reg_read_check(CAP_ADDR, SFC_CAP_RESET);

		for (int i = 0; i < $size(directed_tab); i++) begin
			send_byte(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].verdict);
		end
		settle();

		// Random phases, each under its own capacity setting
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: cap = SFC_CAP_RESET;
				1: cap = 32'h0;
				2: cap = $urandom_range(0, 24);
				default: cap = $urandom();
			endcase
			reg_write(CAP_ADDR, cap);
			if (ph == 1) begin
				// write to an unmapped address must leave capacity alone
				reg_write(UNUSED_ADDR, $urandom());
			end
			reg_read_check(CAP_ADDR, cap);
			fed_target = bytes_fed + RANDOM_PER_PHASE;
			while (bytes_fed < fed_target) send_random_frame();
			settle();
		end

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
